FILE: rtl/core/ssh_pkg.sv
// Package for the spaced seed hit counter: configuration register layout,
// register index codes, reset values and score limits. No dependencies.
`timescale 1ns / 1ps

package ssh_pkg;

  // Configuration as held in the register file
  typedef struct packed {
    logic [31:0]        seed_mask;
    logic [5:0]         seed_length;
    logic signed [5:0]  match_score;
    logic signed [5:0]  mismatch_score;
  } cfg_t;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_SEED_MASK      = 2'd0,
    REG_SEED_LENGTH    = 2'd1,
    REG_MATCH_SCORE    = 2'd2,
    REG_MISMATCH_SCORE = 2'd3
  } reg_idx_t;

  localparam int          ADDR_W             = 4;
  localparam int          DATA_W             = 32;
  localparam logic [31:0] SEED_MASK_RST      = 32'hFFFF_FFFF;
  localparam logic [5:0]  SEED_LENGTH_RST    = 6'd11;
  localparam logic [5:0]  MATCH_SCORE_RST    = 6'd1;
  localparam logic [5:0]  MISMATCH_SCORE_RST = 6'h3C;

  localparam int SCORE_W   = 16;
  localparam int SCORE_MAX = 32767;
  localparam int SCORE_MIN = -32768;

endpackage

FILE: rtl/core/spaced_seed_hit_counter_top.sv
// Spaced seed hit counter, top level: one similarity bit per beat, one
// result beat per read. The beat carrying last passes the snapshot, product
// and sum registers in turn before out_valid rises; out_stall can hold it.
// Throughput: one input beat per cycle while in_stall is low.
// Reset (rst_n low, synchronous) clears read state and pipeline valids and
// loads register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module spaced_seed_hit_counter_top #(
  parameter int MAX_SEED = 32,
  parameter int MAX_READ = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ssh_pkg::ADDR_W-1:0]            paddr,
  input  logic [ssh_pkg::DATA_W-1:0]            pwdata,
  output logic [ssh_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_match_bit,
  input  logic                                  in_last,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [$clog2(MAX_READ+1)-1:0]         out_mismatches,
  output logic signed [ssh_pkg::SCORE_W-1:0]    out_score,
  output logic [$clog2(MAX_READ+1)-1:0]         out_overlap_hits,
  output logic [$clog2(MAX_READ+1)-1:0]         out_spaced_hits,
  output logic [$clog2(MAX_READ+1)-1:0]         out_covered_positions
);
  import ssh_pkg::*;

  localparam int CW = $clog2(MAX_READ + 1);

  cfg_t          cfg;
  logic          snap_valid, snap_ready;
  logic [CW-1:0] snap_pos, snap_mism, snap_overlap, snap_spaced, snap_covered;
  logic [MAX_SEED-1:0] snap_cover;

  // Register file: writes land on the access phase, reads are combinational
  ssh_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Window, cover and counters advance on every accepted beat; a last beat
  // drops the read state and hands the finished counts to the snapshot.
  ssh_seed_core #(
    .MAX_SEED (MAX_SEED),
    .MAX_READ (MAX_READ)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_match_bit (in_match_bit),
    .in_last      (in_last),
    .snap_ready   (snap_ready),
    .snap_valid   (snap_valid),
    .snap_pos     (snap_pos),
    .snap_mism    (snap_mism),
    .snap_overlap (snap_overlap),
    .snap_spaced  (snap_spaced),
    .snap_covered (snap_covered),
    .snap_cover   (snap_cover)
  );

  // Score and coverage finish over two registered stages; the output
  // register holds a result beat while the next read streams in.
  ssh_result_pipe #(
    .MAX_SEED (MAX_SEED),
    .MAX_READ (MAX_READ)
  ) u_pipe (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .snap_valid            (snap_valid),
    .snap_ready            (snap_ready),
    .snap_pos              (snap_pos),
    .snap_mism             (snap_mism),
    .snap_overlap          (snap_overlap),
    .snap_spaced           (snap_spaced),
    .snap_covered          (snap_covered),
    .snap_cover            (snap_cover),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_mismatches        (out_mismatches),
    .out_score             (out_score),
    .out_overlap_hits      (out_overlap_hits),
    .out_spaced_hits       (out_spaced_hits),
    .out_covered_positions (out_covered_positions)
  );

endmodule

FILE: rtl/core/ssh_cfg_regs.sv
// APB-style configuration registers for the spaced seed hit counter.
// Depends on ssh_pkg for the register layout, index codes and reset values.
`timescale 1ns / 1ps

module ssh_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssh_pkg::ADDR_W-1:0] paddr,
  input  logic [ssh_pkg::DATA_W-1:0] pwdata,
  output logic [ssh_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ssh_pkg::cfg_t              cfg
);
  import ssh_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed_mask      <= SEED_MASK_RST;
      cfg_r.seed_length    <= SEED_LENGTH_RST;
      cfg_r.match_score    <= MATCH_SCORE_RST;
      cfg_r.mismatch_score <= MISMATCH_SCORE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SEED_MASK:      cfg_r.seed_mask      <= pwdata[31:0];
        REG_SEED_LENGTH:    cfg_r.seed_length    <= pwdata[5:0];
        REG_MATCH_SCORE:    cfg_r.match_score    <= pwdata[5:0];
        REG_MISMATCH_SCORE: cfg_r.mismatch_score <= pwdata[5:0];
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEED_MASK:      prdata = cfg_r.seed_mask;
      REG_SEED_LENGTH:    prdata = {26'd0, cfg_r.seed_length};
      REG_MATCH_SCORE:    prdata = {26'd0, cfg_r.match_score};
      REG_MISMATCH_SCORE: prdata = {26'd0, cfg_r.mismatch_score};
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/ssh_seed_core.sv
// Per-read state of the spaced seed hit counter: window and cover shift
// registers, saturating counters, greedy skip counter and the end-of-read
// snapshot register. Depends on ssh_pkg for the configuration type.
`timescale 1ns / 1ps

module ssh_seed_core #(
  parameter int MAX_SEED = 32,
  parameter int MAX_READ = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssh_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_match_bit,
  input  logic                                in_last,
  input  logic                                snap_ready,
  output logic                                snap_valid,
  output logic [$clog2(MAX_READ+1)-1:0]       snap_pos,
  output logic [$clog2(MAX_READ+1)-1:0]       snap_mism,
  output logic [$clog2(MAX_READ+1)-1:0]       snap_overlap,
  output logic [$clog2(MAX_READ+1)-1:0]       snap_spaced,
  output logic [$clog2(MAX_READ+1)-1:0]       snap_covered,
  output logic [MAX_SEED-1:0]                 snap_cover
);
  import ssh_pkg::*;

  localparam int CW = $clog2(MAX_READ + 1);
  localparam int LW = $clog2(MAX_SEED + 1);
  localparam int IW = $clog2(MAX_SEED);
  localparam int MS = MAX_SEED;
  localparam logic [CW-1:0] MAXR = CW'(MAX_READ);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (c < MAXR) ? c + 1'b1 : c;
  endfunction

  logic [MS-1:0] window_r, window_nxt;
  logic [MS-1:0] cover_r, cover_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] mism_r, mism_nxt;
  logic [CW-1:0] overlap_r, overlap_nxt;
  logic [CW-1:0] spaced_r, spaced_nxt;
  logic [CW-1:0] covered_r, covered_nxt;
  logic [LW-1:0] skip_r, skip_nxt;

  logic          snap_valid_r;
  logic [CW-1:0] snap_pos_r, snap_mism_r, snap_overlap_r, snap_spaced_r, snap_covered_r;
  logic [MS-1:0] snap_cover_r;

  logic [LW-1:0] len;
  logic [MS-1:0] lm;
  logic [63:0]   mask64;
  logic [MS-1:0] mask_ext, mask_rev, req;
  logic [IW-1:0] leave_idx;
  logic          hit, active, accept;

  // Effective seed length: zero reads as one, clamp to the window width
  always_comb begin
    if (cfg.seed_length == 6'd0) begin
      len = LW'(1);
    end else if (int'(cfg.seed_length) > MS) begin
      len = LW'(MS);
    end else begin
      len = LW'(cfg.seed_length);
    end
  end

  // Required-match pattern: seed position t maps to window age len-1-t
  assign mask64 = {32'd0, cfg.seed_mask};
  assign mask_ext = mask64[MS-1:0];
  always_comb begin
    for (int i = 0; i < MS; i++) begin
      lm[i]       = (i < int'(len));
      mask_rev[i] = mask_ext[MS-1-i];
    end
  end
  assign req       = (mask_rev >> (LW'(MS) - len)) & lm;
  assign leave_idx = IW'(len - 1'b1);

  assign accept   = in_valid && !in_stall;
  assign in_stall = snap_valid_r && !snap_ready;

  always_comb begin
    window_nxt  = {window_r[MS-2:0], in_match_bit};
    cover_nxt   = (cover_r << 1) & lm;
    covered_nxt = cover_r[leave_idx] ? sat_inc(covered_r) : covered_r;
    pos_nxt     = sat_inc(pos_r);
    mism_nxt    = in_match_bit ? mism_r : sat_inc(mism_r);
    overlap_nxt = overlap_r;
    spaced_nxt  = spaced_r;
    skip_nxt    = skip_r;
    hit         = ((window_nxt & req) == req);
    active      = ({{LW{1'b0}}, pos_nxt} >= {{CW{1'b0}}, len});
    if (active) begin
      if (hit) begin
        overlap_nxt = sat_inc(overlap_r);
        cover_nxt   = cover_nxt | req;
      end
      if (skip_r != '0) begin
        skip_nxt = skip_r - 1'b1;
      end else if (hit) begin
        spaced_nxt = sat_inc(spaced_r);
        skip_nxt   = len - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      cover_r      <= '0;
      pos_r        <= '0;
      mism_r       <= '0;
      overlap_r    <= '0;
      spaced_r     <= '0;
      covered_r    <= '0;
      skip_r       <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last) begin
          window_r  <= '0;
          cover_r   <= '0;
          pos_r     <= '0;
          mism_r    <= '0;
          overlap_r <= '0;
          spaced_r  <= '0;
          covered_r <= '0;
          skip_r    <= '0;
        end else begin
          window_r  <= window_nxt;
          cover_r   <= cover_nxt;
          pos_r     <= pos_nxt;
          mism_r    <= mism_nxt;
          overlap_r <= overlap_nxt;
          spaced_r  <= spaced_nxt;
          covered_r <= covered_nxt;
          skip_r    <= skip_nxt;
        end
      end
      if (accept && in_last) begin
        snap_valid_r <= 1'b1;
      end else if (snap_ready) begin
        snap_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      snap_pos_r     <= pos_nxt;
      snap_mism_r    <= mism_nxt;
      snap_overlap_r <= overlap_nxt;
      snap_spaced_r  <= spaced_nxt;
      snap_covered_r <= covered_nxt;
      snap_cover_r   <= cover_nxt;
    end
  end

  assign snap_valid   = snap_valid_r;
  assign snap_pos     = snap_pos_r;
  assign snap_mism    = snap_mism_r;
  assign snap_overlap = snap_overlap_r;
  assign snap_spaced  = snap_spaced_r;
  assign snap_covered = snap_covered_r;
  assign snap_cover   = snap_cover_r;

`ifndef SYNTHESIS
  a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    snap_valid_r && !snap_ready |=>
      snap_valid_r && $stable(snap_pos_r) && $stable(snap_mism_r))
    else $error("snapshot changed while held");

  a_read_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> pos_r == '0 && skip_r == '0 && cover_r == '0)
    else $error("read state not cleared after last beat");

  a_mism_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mism_r <= pos_r)
    else $error("mismatch count above position count");

  a_spaced_bound: assert property (@(posedge clk) disable iff (!rst_n)
    spaced_r <= overlap_r)
    else $error("greedy hit count above overlap hit count");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_last && !snap_valid_r |=> !snap_valid_r)
    else $error("snapshot raised without a last beat");
`endif

endmodule

FILE: rtl/core/ssh_result_pipe.sv
// Result pipeline of the spaced seed hit counter: score products and cover
// chunk counts, then sums, saturation and the output register.
// Depends on ssh_pkg for the configuration type and score limits.
`timescale 1ns / 1ps

module ssh_result_pipe #(
  parameter int MAX_SEED = 32,
  parameter int MAX_READ = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ssh_pkg::cfg_t                         cfg,
  input  logic                                  snap_valid,
  output logic                                  snap_ready,
  input  logic [$clog2(MAX_READ+1)-1:0]         snap_pos,
  input  logic [$clog2(MAX_READ+1)-1:0]         snap_mism,
  input  logic [$clog2(MAX_READ+1)-1:0]         snap_overlap,
  input  logic [$clog2(MAX_READ+1)-1:0]         snap_spaced,
  input  logic [$clog2(MAX_READ+1)-1:0]         snap_covered,
  input  logic [MAX_SEED-1:0]                   snap_cover,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [$clog2(MAX_READ+1)-1:0]         out_mismatches,
  output logic signed [ssh_pkg::SCORE_W-1:0]    out_score,
  output logic [$clog2(MAX_READ+1)-1:0]         out_overlap_hits,
  output logic [$clog2(MAX_READ+1)-1:0]         out_spaced_hits,
  output logic [$clog2(MAX_READ+1)-1:0]         out_covered_positions
);
  import ssh_pkg::*;

  localparam int CW  = $clog2(MAX_READ + 1);
  localparam int PW  = CW + 7;
  localparam int SW  = (CW + 8 > 17) ? CW + 8 : 17;
  localparam int NCH = (MAX_SEED + 7) / 8;
  localparam logic [CW-1:0] MAXR = CW'(MAX_READ);
  localparam logic signed [SW-1:0] S_MAX = SW'(SCORE_MAX);
  localparam logic signed [SW-1:0] S_MIN = SW'(SCORE_MIN);

  // Stage B: products and chunk counts
  logic                  mid_valid_r;
  logic signed [PW-1:0]  mid_prod_m_r, mid_prod_x_r;
  logic [3:0]            mid_chunk_r [NCH];
  logic [CW-1:0]         mid_covered_r, mid_mism_r, mid_overlap_r, mid_spaced_r;

  // Stage C: output register
  logic                  out_valid_r;
  logic [CW-1:0]         out_mism_r, out_overlap_r, out_spaced_r, out_cov_r;
  logic signed [SCORE_W-1:0] out_score_r;

  logic                  out_rdy, mid_rdy;
  logic [CW-1:0]         match_cnt;
  logic signed [PW-1:0]  prod_m, prod_x;
  logic [NCH*8-1:0]      cov_pad;
  logic [3:0]            chunk [NCH];
  logic [CW:0]           cov_sum;
  logic [CW-1:0]         cov_sat;
  logic signed [SW-1:0]  score_sum, score_sat;

  assign out_rdy    = !out_valid_r || !out_stall;
  assign mid_rdy    = !mid_valid_r || out_rdy;
  assign snap_ready = mid_rdy;

  assign match_cnt = snap_pos - snap_mism;
  assign prod_m  = $signed({1'b0, match_cnt}) * $signed(cfg.match_score);
  assign prod_x  = $signed({1'b0, snap_mism}) * $signed(cfg.mismatch_score);
  assign cov_pad = (NCH*8)'(snap_cover);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      chunk[c] = '0;
      for (int b = 0; b < 8; b++) begin
        chunk[c] = chunk[c] + {3'd0, cov_pad[c*8+b]};
      end
    end
  end

  always_comb begin
    cov_sum = {1'b0, mid_covered_r};
    for (int c = 0; c < NCH; c++) begin
      cov_sum = cov_sum + (CW+1)'(mid_chunk_r[c]);
    end
    cov_sat   = (cov_sum > {1'b0, MAXR}) ? MAXR : cov_sum[CW-1:0];
    score_sum = SW'(mid_prod_m_r) + SW'(mid_prod_x_r);
    if (score_sum > S_MAX) begin
      score_sat = S_MAX;
    end else if (score_sum < S_MIN) begin
      score_sat = S_MIN;
    end else begin
      score_sat = score_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mid_rdy) begin
        mid_valid_r <= snap_valid;
      end
      if (out_rdy) begin
        out_valid_r <= mid_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_rdy && snap_valid) begin
      mid_prod_m_r  <= prod_m;
      mid_prod_x_r  <= prod_x;
      mid_chunk_r   <= chunk;
      mid_covered_r <= snap_covered;
      mid_mism_r    <= snap_mism;
      mid_overlap_r <= snap_overlap;
      mid_spaced_r  <= snap_spaced;
    end
    if (out_rdy && mid_valid_r) begin
      out_mism_r    <= mid_mism_r;
      out_overlap_r <= mid_overlap_r;
      out_spaced_r  <= mid_spaced_r;
      out_cov_r     <= cov_sat;
      out_score_r   <= score_sat[SCORE_W-1:0];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_mismatches        = out_mism_r;
  assign out_score             = out_score_r;
  assign out_overlap_hits      = out_overlap_r;
  assign out_spaced_hits       = out_spaced_r;
  assign out_covered_positions = out_cov_r;

endmodule

FILE: tb/spaced_seed_hit_counter_top_tb.sv
// Self-checking testbench for spaced_seed_hit_counter_top: directed reads from a
// table, then random reads under three idle profiles, checked by a local predictor.
// Depends on ssh_pkg and the spaced_seed_hit_counter_top RTL only.
`timescale 1ns / 1ps

module spaced_seed_hit_counter_top_tb;
  import ssh_pkg::*;

  localparam int MAX_SEED     = 32;
  localparam int MAX_READ     = 1024;
  localparam int CNT_W        = $clog2(MAX_READ + 1);
  // Drain margin after the last result, on top of the pipeline depth.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BEATS  = 175;

  // One result beat: the five per-read totals.
  typedef struct packed {
    logic [CNT_W-1:0]  mismatches;
    logic signed [15:0] score;
    logic [CNT_W-1:0]  overlap_hits;
    logic [CNT_W-1:0]  spaced_hits;
    logic [CNT_W-1:0]  covered_positions;
  } totals_t;

  // One row of the directed table: a register write or an input beat,
  // optionally with the totals typed in by hand.
  typedef struct {
    bit          is_reg;
    reg_idx_t    idx;
    logic [31:0] wdata;
    bit          mb;
    bit          lst;
    bit          typed;
    totals_t     want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [ADDR_W-1:0]    paddr        = '0;
  logic [DATA_W-1:0]    pwdata       = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 in_match_bit = 1'b0;
  logic                 in_last      = 1'b0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [CNT_W-1:0]     out_mismatches;
  logic signed [15:0]   out_score;
  logic [CNT_W-1:0]     out_overlap_hits;
  logic [CNT_W-1:0]     out_spaced_hits;
  logic [CNT_W-1:0]     out_covered_positions;

  // Idle profile, changed between phases by the main sequence.
  int unsigned send_idle_pct = 36;
  int unsigned stall_pct     = 87;

  int unsigned error_count  = 0;
  int unsigned beats_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned cycle_count  = 0;

  totals_t expected_totals[$];

  // Shadow of the configuration registers.
  logic [31:0]        mask_r = SEED_MASK_RST;
  logic [5:0]         len_r  = SEED_LENGTH_RST;
  logic signed [5:0]  ms_r   = MATCH_SCORE_RST;
  logic signed [5:0]  mms_r  = MISMATCH_SCORE_RST;

  // Per-read state of the predictor.
  logic [31:0] win_q  = '0;   // recent match bits, bit 0 newest
  logic [31:0] cov_q  = '0;   // covered flags of the same positions
  int unsigned pos_n  = 0;
  int unsigned mis_n  = 0;
  int unsigned ovl_n  = 0;
  int unsigned spc_n  = 0;
  int unsigned cvd_n  = 0;    // covered positions already shifted out
  int unsigned skip_n = 0;    // window starts still skipped for greedy hits

  spaced_seed_hit_counter_top #(
    .MAX_SEED(MAX_SEED),
    .MAX_READ(MAX_READ)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_match_bit         (in_match_bit),
    .in_last              (in_last),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_mismatches       (out_mismatches),
    .out_score            (out_score),
    .out_overlap_hits     (out_overlap_hits),
    .out_spaced_hits      (out_spaced_hits),
    .out_covered_positions(out_covered_positions)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Length register as the block uses it: 0 reads as 1, anything above
  // the seed capacity reads as the capacity.
  function automatic int unsigned seed_span(logic [5:0] l);
    if (l < 1) return 1;
    if (l > MAX_SEED) return MAX_SEED;
    return l;
  endfunction

  function automatic int unsigned sat_up(int unsigned c);
    return (c < MAX_READ) ? c + 1 : c;
  endfunction

  function automatic int pick_score();
    case ($urandom_range(3))
      0:       return -16;
      1:       return 16;
      default: return int'($urandom_range(32)) - 16;
    endcase
  endfunction

  function automatic totals_t make_totals(int m, int s, int o, int sp, int c);
    totals_t t;
    t.mismatches        = CNT_W'(m);
    t.score             = 16'(s);
    t.overlap_hits      = CNT_W'(o);
    t.spaced_hits       = CNT_W'(sp);
    t.covered_positions = CNT_W'(c);
    return t;
  endfunction

  function automatic stim_row_t reg_row(reg_idx_t idx, logic [31:0] v);
    stim_row_t r;
    r = '{idx: REG_SEED_MASK, default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.wdata  = v;
    return r;
  endfunction

  function automatic stim_row_t beat_row(bit mb, bit lst);
    stim_row_t r;
    r = '{idx: REG_SEED_MASK, default: '0};
    r.mb  = mb;
    r.lst = lst;
    return r;
  endfunction

  function automatic stim_row_t read_end_row(bit mb, totals_t want);
    stim_row_t r;
    r       = beat_row(mb, 1'b1);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic signed [16:0] got,
                               input logic signed [16:0] want);
    if (got !== want)
      report_error($sformatf("%s: got %0d, want %0d", name, got, want));
  endtask

  // Advance the predictor by one accepted beat; on the last beat of a read
  // hand back the totals and clear the read state.
  task automatic tally_position(input bit mb, input bit lst, output bit done,
                                output totals_t res);
    int unsigned len;
    int unsigned t;
    int unsigned cov;
    int          sc;
    logic [31:0] lm;
    logic [31:0] req;
    bit          hit;
    len  = seed_span(len_r);
    lm   = (len == 32) ? '1 : ((32'd1 << len) - 1);
    done = 1'b0;
    res  = '0;

    win_q = {win_q[30:0], mb};
    // The oldest position of the window leaves every future window here.
    if (cov_q[len-1]) cvd_n = sat_up(cvd_n);
    cov_q = (cov_q << 1) & lm;
    pos_n = sat_up(pos_n);
    if (!mb) mis_n = sat_up(mis_n);

    if (pos_n >= len) begin
      // Seed position t lines up with window age len-1-t.
      req = '0;
      for (t = 0; t < len; t++)
        if (mask_r[t]) req[len-1-t] = 1'b1;
      hit = ((win_q & req) == req);
      if (hit) begin
        ovl_n = sat_up(ovl_n);
        cov_q = cov_q | req;
      end
      if (skip_n > 0) begin
        skip_n--;
      end else if (hit) begin
        spc_n  = sat_up(spc_n);
        skip_n = len - 1;
      end
    end

    if (lst) begin
      sc = (int'(pos_n) - int'(mis_n)) * int'(ms_r) + int'(mis_n) * int'(mms_r);
      if (sc > SCORE_MAX) sc = SCORE_MAX;
      if (sc < SCORE_MIN) sc = SCORE_MIN;
      cov = cvd_n + $countones(cov_q & lm);
      if (cov > MAX_READ) cov = MAX_READ;
      res  = make_totals(mis_n, sc, ovl_n, spc_n, cov);
      done = 1'b1;
      win_q = '0; cov_q = '0;
      pos_n = 0; mis_n = 0; ovl_n = 0; spc_n = 0; cvd_n = 0; skip_n = 0;
    end
  endtask

  // Drive one input beat, entered and left at a falling edge. Insert random
  // gaps first, hold the payload until accepted, then predict.
  task automatic send_beat(input bit mb, input bit lst, input bit typed,
                           input totals_t want);
    bit      done;
    totals_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_match_bit <= mb;
    in_last      <= lst;
    do @(posedge clk); while (in_stall !== 1'b0);
    beats_sent++;
    tally_position(mb, lst, done, pred);
    // A typed row overrides the predicted totals, so a predictor slip
    // cannot hide a block error on those rows.
    if (done) expected_totals.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic send_read(input int unsigned n, input int unsigned match_pct);
    int unsigned i;
    for (i = 0; i < n; i++)
      send_beat($urandom_range(99) < match_pct, i == n - 1, 1'b0, '0);
  endtask

  // Drop valid and wait until every pending read has come out, plus the
  // pipeline depth for beats that carry no result.
  task automatic hold_off();
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Setup cycle, access cycle, then psel low before returning, so that back-to-back
  // writes never assign psel twice in one step.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_SEED_MASK:      mask_r = val;
      REG_SEED_LENGTH:    len_r  = val[5:0];
      REG_MATCH_SCORE:    ms_r   = val[5:0];
      REG_MISMATCH_SCORE: mms_r  = val[5:0];
      default:            ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // New random seed and scores, biased toward the corners.
  task automatic random_setting();
    logic [31:0] m;
    logic [5:0]  l;
    hold_off();
    case ($urandom_range(5))
      0:       m = '1;
      1:       m = '0;
      2:       m = 32'd1 << $urandom_range(31);
      default: m = $urandom;
    endcase
    write_reg(REG_SEED_MASK, m);
    case ($urandom_range(9))
      0:       l = 6'd0;
      1:       l = 6'd1;
      2:       l = 6'd32;
      3:       l = 6'($urandom_range(63, 33));
      default: l = 6'($urandom_range(12, 2));
    endcase
    write_reg(REG_SEED_LENGTH, {26'd0, l});
    write_reg(REG_MATCH_SCORE, 32'(pick_score()));
    write_reg(REG_MISMATCH_SCORE, 32'(pick_score()));
  endtask

  // Receiver: pick a new stall decision every cycle.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Check every accepted result beat against the oldest pending read.
  always @(posedge clk) begin : check_totals
    totals_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_totals.size() == 0) begin
        report_error("result beat with no read pending");
      end else begin
        want = expected_totals.pop_front();
        results_seen++;
        compare_field("mismatches", out_mismatches, want.mismatches);
        compare_field("score", out_score, want.score);
        compare_field("overlap_hits", out_overlap_hits, want.overlap_hits);
        compare_field("spaced_hits", out_spaced_hits, want.spaced_hits);
        compare_field("covered_positions", out_covered_positions,
                      want.covered_positions);
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    stim_row_t   plan[$];
    int unsigned phase;
    int unsigned start_beats;
    int unsigned rl;
    int unsigned pct;

    // Hold reset, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: read shorter than the seed, so no windows complete.
    plan.push_back(beat_row(1'b1, 1'b0));
    plan.push_back(beat_row(1'b0, 1'b0));
    plan.push_back(read_end_row(1'b1, make_totals(1, -2, 0, 0, 0)));
    // Length 0 acts as 1; mask bits above the length are ignored.
    plan.push_back(reg_row(REG_SEED_LENGTH, 32'd0));
    plan.push_back(beat_row(1'b1, 1'b0));
    plan.push_back(beat_row(1'b1, 1'b0));
    plan.push_back(beat_row(1'b0, 1'b0));
    plan.push_back(read_end_row(1'b1, make_totals(1, -1, 3, 3, 3)));
    // Length above capacity clamps to 32; scores of -16 and 16, inverted signs.
    plan.push_back(reg_row(REG_SEED_LENGTH, 32'd63));
    plan.push_back(reg_row(REG_MATCH_SCORE, 32'(-16)));
    plan.push_back(reg_row(REG_MISMATCH_SCORE, 32'(16)));
    plan.push_back(beat_row(1'b0, 1'b0));
    plan.push_back(read_end_row(1'b0, make_totals(2, 32, 0, 0, 0)));
    // Empty mask: every window hits, nothing gets covered.
    plan.push_back(reg_row(REG_SEED_LENGTH, 32'd2));
    plan.push_back(reg_row(REG_SEED_MASK, 32'd0));
    plan.push_back(reg_row(REG_MATCH_SCORE, 32'(16)));
    plan.push_back(reg_row(REG_MISMATCH_SCORE, 32'(-16)));
    plan.push_back(beat_row(1'b0, 1'b0));
    plan.push_back(beat_row(1'b0, 1'b0));
    plan.push_back(read_end_row(1'b0, make_totals(3, -48, 2, 1, 0)));
    // Seed shortened in the middle of a read: cover bits beyond the new
    // length drop out uncounted.
    plan.push_back(reg_row(REG_SEED_LENGTH, 32'd3));
    plan.push_back(reg_row(REG_SEED_MASK, 32'hFFFF_FFF5));
    plan.push_back(beat_row(1'b1, 1'b0));
    plan.push_back(beat_row(1'b1, 1'b0));
    plan.push_back(beat_row(1'b1, 1'b0));
    plan.push_back(reg_row(REG_SEED_LENGTH, 32'd2));
    plan.push_back(beat_row(1'b1, 1'b0));
    plan.push_back(beat_row(1'b1, 1'b1));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        hold_off();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_beat(plan[i].mb, plan[i].lst, plan[i].typed, plan[i].want);
      end
    end

    // Random reads under three idle profiles: slow receiver, slow sender,
    // then full rate on both sides.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 36; stall_pct = 87; end
        1:       begin send_idle_pct = 87; stall_pct = 36; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      start_beats = beats_sent;
      while (beats_sent - start_beats < PHASE_BEATS) begin
        random_setting();
        repeat (4) begin
          if ($urandom_range(7) == 0)
            rl = 1;
          else
            rl = $urandom_range(2 * seed_span(len_r) + 6, 1);
          case ($urandom_range(3))
            0:       pct = 50;
            1:       pct = 85;
            2:       pct = 97;
            default: pct = 100;
          endcase
          send_read(rl, pct);
          // Now and then let the block drain completely before going on.
          if ($urandom_range(5) == 0) hold_off();
        end
      end
      // A long read runs the position counter into saturation, and the overlap hit counter too for short seeds.
      if (phase == 2) send_read(1040, 100);
    end

    hold_off();
    $display("Covered %0d input beats and %0d read results across %0d register writes,",
             beats_sent, results_seen, reg_writes);
    $display("including clamped seed lengths, empty and full masks and saturating reads.");
    if (error_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: spaced_seed_hit_counter_top.f
rtl/core/ssh_pkg.sv
rtl/core/ssh_cfg_regs.sv
rtl/core/ssh_seed_core.sv
rtl/core/ssh_result_pipe.sv
rtl/core/spaced_seed_hit_counter_top.sv
tb/spaced_seed_hit_counter_top_tb.sv
